// ===== sv/csvrd_pkg.sv =====
// types and constants shared by the csv record deframer
package csvrd_pkg;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   localparam logic FUNC_DATA  = 1'b0;
   localparam logic FUNC_FLUSH = 1'b1;

   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      KIND_BYTE       = 2'd0,
      KIND_FIELD_END  = 2'd1,
      KIND_RECORD_END = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] out_byte;
      logic       is_header;
      logic       last_of_run;
   } result_type;

   // results of one input beat: the first is always present
   typedef struct packed {
      logic       second_valid;
      result_type first;
      result_type second;
   } pair_type;

endpackage

// ===== sv/csvrd_if.sv =====
// valid/ready channel interfaces for the request and response sides
interface csvrd_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] data_byte;

   modport source (output valid, output func, output data_byte, input ready);
   modport sink (input valid, input func, input data_byte, output ready);
endinterface

interface csvrd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] out_byte;
   logic       is_header;
   logic       last_of_run;

   modport source (output valid, output kind, output out_byte, output is_header,
                   output last_of_run, input ready);
   modport sink (input valid, input kind, input out_byte, input is_header,
                 input last_of_run, output ready);
endinterface

// ===== sv/csv_record_deframer.sv =====
// csv record deframer top level: front end, pair queue and back end
// accepts one input beat per cycle while the pair queue has room; each beat gives zero,
// one or two response beats, shown through the pair queue and then the output register
// throughput: one response beat per cycle from the output register while rsp_ch is ready,
//   so beats with two results take two response beats; a four-entry pair queue absorbs bursts
// reset clears the line state, sets the header flag and empties queue and output register
module csv_record_deframer (
   input  logic       clock,
   input  logic       reset,
   csvrd_req_if.sink  req_ch,
   csvrd_rsp_if.source rsp_ch
);
   import csvrd_pkg::*;

   logic     push_valid;
   logic     push_ready;
   pair_type push_pair;
   logic     pop_valid;
   logic     pop_ready;
   pair_type pop_pair;

   csvrd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_pair  (push_pair),
      .push_ready (push_ready)
   );

   csvrd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_pair  (push_pair),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_pair   (pop_pair),
      .pop_ready  (pop_ready)
   );

   csvrd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_pair  (pop_pair),
      .pop_ready (pop_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ===== sv/csvrd_front.sv =====
// front end: takes input beats, tracks quoting and line state, builds result pairs
module csvrd_front (
   input  logic               clock,
   input  logic               reset,
   csvrd_req_if.sink          req_ch,
   output logic               push_valid,
   output csvrd_pkg::pair_type push_pair,
   input  logic               push_ready
);
   import csvrd_pkg::*;

   logic quoted_mode_ff, quoted_mode_in;
   logic quote_pending_ff, quote_pending_in;
   logic cr_held_ff, cr_held_in;
   logic line_started_ff, line_started_in;
   logic header_next_ff, header_next_in;

   logic       accept;
   logic       pre_valid;
   logic       main_valid;
   kind_type   main_kind;
   logic [7:0] main_byte;
   logic       done;
   logic [7:0] b;

   assign req_ch.ready = push_ready;
   assign accept       = req_ch.valid && push_ready;
   assign b            = req_ch.data_byte;

   always_comb begin
      quoted_mode_in   = quoted_mode_ff;
      quote_pending_in = quote_pending_ff;
      cr_held_in       = cr_held_ff;
      line_started_in  = line_started_ff;
      header_next_in   = header_next_ff;
      pre_valid        = 1'b0;
      main_valid       = 1'b0;
      main_kind        = KIND_BYTE;
      main_byte        = 8'd0;
      done             = 1'b0;
      if (req_ch.func == FUNC_FLUSH) begin
         if (line_started_ff) begin
            main_valid = 1'b1;
            main_kind  = KIND_RECORD_END;
         end
         quoted_mode_in   = 1'b0;
         quote_pending_in = 1'b0;
         cr_held_in       = 1'b0;
         line_started_in  = 1'b0;
         header_next_in   = 1'b1;
      end else if (b == CH_LF) begin
         if (line_started_ff) begin
            main_valid     = 1'b1;
            main_kind      = KIND_RECORD_END;
            header_next_in = 1'b0;
         end
         quoted_mode_in   = 1'b0;
         quote_pending_in = 1'b0;
         cr_held_in       = 1'b0;
         line_started_in  = 1'b0;
      end else begin
         // a held return that is not a line end becomes content
         if (cr_held_ff) begin
            pre_valid       = 1'b1;
            cr_held_in      = 1'b0;
            line_started_in = 1'b1;
         end
         if (quote_pending_ff) begin
            quote_pending_in = 1'b0;
            if (b == CH_QUOTE) begin
               main_valid = 1'b1;
               main_byte  = CH_QUOTE;
               done       = 1'b1;
            end else begin
               quoted_mode_in = 1'b0;
            end
         end
         if (!done) begin
            if (b == CH_CR) begin
               cr_held_in = 1'b1;
            end else begin
               line_started_in = 1'b1;
               if (quoted_mode_in) begin
                  if (b == CH_QUOTE) begin
                     quote_pending_in = 1'b1;
                  end else begin
                     main_valid = 1'b1;
                     main_byte  = b;
                  end
               end else if (b == CH_QUOTE) begin
                  quoted_mode_in = 1'b1;
               end else if (b == CH_COMMA) begin
                  main_valid = 1'b1;
                  main_kind  = KIND_FIELD_END;
               end else begin
                  main_valid = 1'b1;
                  main_byte  = b;
               end
            end
         end
      end
   end

   always_comb begin
      push_pair.second_valid       = pre_valid && main_valid;
      push_pair.first.is_header    = header_next_ff;
      push_pair.second.is_header   = header_next_ff;
      push_pair.first.last_of_run  = !(pre_valid && main_valid);
      push_pair.second.last_of_run = 1'b1;
      push_pair.second.kind        = main_kind;
      push_pair.second.out_byte    = main_byte;
      if (pre_valid) begin
         push_pair.first.kind     = KIND_BYTE;
         push_pair.first.out_byte = CH_CR;
      end else begin
         push_pair.first.kind     = main_kind;
         push_pair.first.out_byte = main_byte;
      end
   end

   assign push_valid = accept && (pre_valid || main_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         quoted_mode_ff   <= 1'b0;
         quote_pending_ff <= 1'b0;
         cr_held_ff       <= 1'b0;
         line_started_ff  <= 1'b0;
         header_next_ff   <= 1'b1;
      end else if (accept) begin
         quoted_mode_ff   <= quoted_mode_in;
         quote_pending_ff <= quote_pending_in;
         cr_held_ff       <= cr_held_in;
         line_started_ff  <= line_started_in;
         header_next_ff   <= header_next_in;
      end
   end

   a_pending_only_quoted: assert property (@(posedge clock) disable iff (reset)
      quote_pending_ff |-> quoted_mode_ff)
      else $error("quote pending outside quoted mode");

   a_cr_starts_nothing: assert property (@(posedge clock) disable iff (reset)
      cr_held_ff |-> !quote_pending_ff)
      else $error("return held while a quote is pending");

endmodule

// ===== sv/csvrd_queue.sv =====
// short queue of result pairs between front and back
module csvrd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  csvrd_pkg::pair_type push_pair,
   output logic                push_ready,
   output logic                pop_valid,
   output csvrd_pkg::pair_type pop_pair,
   input  logic                pop_ready
);
   import csvrd_pkg::*;

   localparam int PtrWidth = $clog2(QUEUE_DEPTH);
   localparam int CntWidth = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CntWidth-1:0] FullCount = CntWidth'(QUEUE_DEPTH);

   pair_type              entry_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = (count_ff != FullCount);
   assign pop_valid  = (count_ff != '0);
   assign pop_pair   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_pair;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCount)
      else $error("queue fill count beyond depth");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> push_ready)
      else $error("front pushed into a full queue");

endmodule

// ===== sv/csvrd_back.sv =====
// back end: unpacks result pairs into single response beats through an output register
module csvrd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   input  csvrd_pkg::pair_type pop_pair,
   output logic                pop_ready,
   csvrd_rsp_if.source         rsp_ch
);
   import csvrd_pkg::*;

   logic       sel_ff, sel_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;
   logic       load;

   assign load      = pop_valid && (!rsp_valid_ff || rsp_ch.ready);
   assign pop_ready = load && (sel_ff || !pop_pair.second_valid);

   always_comb begin
      sel_in       = sel_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = sel_ff ? pop_pair.second : pop_pair.first;
         sel_in       = !sel_ff && pop_pair.second_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.kind        = rsp_data_ff.kind;
   assign rsp_ch.out_byte    = rsp_data_ff.out_byte;
   assign rsp_ch.is_header   = rsp_data_ff.is_header;
   assign rsp_ch.last_of_run = rsp_data_ff.last_of_run;

   a_second_half_waits: assert property (@(posedge clock) disable iff (reset)
      sel_ff |-> (pop_valid && pop_pair.second_valid))
      else $error("second result selected but no pair waiting");

   a_first_of_two_marks_sel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.last_of_run) |-> sel_ff)
      else $error("first of a pair shown without its second pending");

endmodule

// ===== dv/csv_record_deframer_tb.sv =====
// self-checking testbench for the csv record deframer: directed and random text streams
module csv_record_deframer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import csvrd_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 8;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_BEATS = 1000;
   localparam int BURST_BEATS  = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic rsp_ready_drv = 1'b0;
   logic back_to_back = 1'b0;

   csvrd_req_if req_if ();
   csvrd_rsp_if rsp_if ();

   assign rsp_if.ready = rsp_ready_drv;

   csv_record_deframer uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // predictor line state
   logic quoted_on;
   logic quote_seen;
   logic return_held;
   logic line_open;
   logic header_due;

   result_type expected_results[$];

   int errors = 0;
   int beats_sent = 0;
   int directed_beats = 0;
   int results_checked = 0;
   int records_seen = 0;
   int header_records = 0;

   always #(HALF_PERIOD) clock = ~clock;

   always @(negedge clock) begin
      rsp_ready_drv <= back_to_back || ($urandom_range(0, 99) >= 34);
   end

   function automatic void clear_line_state();
      quoted_on   = 1'b0;
      quote_seen  = 1'b0;
      return_held = 1'b0;
      line_open   = 1'b0;
   endfunction

   function automatic void push_result(kind_type k, logic [7:0] b);
      result_type r;
      r.kind        = k;
      r.out_byte    = (k == KIND_BYTE) ? b : 8'h00;
      r.is_header   = header_due;
      r.last_of_run = 1'b0;
      expected_results = {expected_results, r};
   endfunction

   task automatic predict_beat(input logic func, input logic [7:0] b);
      int size_at_start;
      logic taken;
      size_at_start = expected_results.size();
      taken = 1'b0;
      if (func == FUNC_FLUSH) begin
         if (line_open) push_result(KIND_RECORD_END, 8'h00);
         clear_line_state();
         header_due = 1'b1;
      end else if (b == CH_LF) begin
         // newline always ends the line, quotes or not
         if (line_open) begin
            push_result(KIND_RECORD_END, 8'h00);
            header_due = 1'b0;
         end
         clear_line_state();
      end else begin
         if (return_held) begin
            push_result(KIND_BYTE, CH_CR);
            return_held = 1'b0;
            line_open = 1'b1;
         end
         if (quote_seen) begin
            quote_seen = 1'b0;
            if (b == CH_QUOTE) begin
               push_result(KIND_BYTE, CH_QUOTE);
               taken = 1'b1;
            end else begin
               quoted_on = 1'b0;
            end
         end
         if (!taken) begin
            if (b == CH_CR) begin
               return_held = 1'b1;
            end else begin
               line_open = 1'b1;
               if (quoted_on) begin
                  if (b == CH_QUOTE) quote_seen = 1'b1;
                  else push_result(KIND_BYTE, b);
               end else if (b == CH_QUOTE) begin
                  quoted_on = 1'b1;
               end else if (b == CH_COMMA) begin
                  push_result(KIND_FIELD_END, 8'h00);
               end else begin
                  push_result(KIND_BYTE, b);
               end
            end
         end
      end
      if (expected_results.size() > size_at_start)
         expected_results[expected_results.size() - 1].last_of_run = 1'b1;
   endtask

   // called at a falling edge; returns at the falling edge after the beat is taken
   task automatic send_beat(input logic func, input logic [7:0] b);
      while (!back_to_back && $urandom_range(0, 99) < 34) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.func      <= func;
      req_if.data_byte <= b;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      predict_beat(func, b);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_beat(FUNC_DATA, s[i]);
   endtask

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == CH_QUOTE || b == CH_COMMA || b == CH_CR || b == CH_LF);
      return b;
   endfunction

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 7))
         0: return CH_QUOTE;
         1: return CH_COMMA;
         2: return CH_CR;
         3: return CH_LF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // one csv line with random fields, mostly well formed
   task automatic send_record();
      int nfields;
      int len;
      int style;
      nfields = $urandom_range(1, 4);
      for (int f = 0; f < nfields; f++) begin
         if (f > 0) send_beat(FUNC_DATA, CH_COMMA);
         style = $urandom_range(0, 9);
         len = $urandom_range(0, 6);
         if (style < 6) begin
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(0, 19) == 0) send_beat(FUNC_DATA, CH_CR);
               else send_beat(FUNC_DATA, plain_byte());
            end
         end else if (style < 9) begin
            send_beat(FUNC_DATA, CH_QUOTE);
            for (int i = 0; i < len; i++) begin
               case ($urandom_range(0, 9))
                  0: begin
                     send_beat(FUNC_DATA, CH_QUOTE);
                     send_beat(FUNC_DATA, CH_QUOTE);
                  end
                  1: send_beat(FUNC_DATA, CH_COMMA);
                  2: send_beat(FUNC_DATA, CH_CR);
                  3: begin
                     // occasional newline inside quotes breaks the record
                     if ($urandom_range(0, 3) == 0) send_beat(FUNC_DATA, CH_LF);
                     else send_beat(FUNC_DATA, plain_byte());
                  end
                  default: send_beat(FUNC_DATA, plain_byte());
               endcase
            end
            send_beat(FUNC_DATA, CH_QUOTE);
            if ($urandom_range(0, 7) == 0) send_beat(FUNC_DATA, plain_byte());
         end
      end
      if ($urandom_range(0, 1) == 1) send_beat(FUNC_DATA, CH_CR);
      send_beat(FUNC_DATA, CH_LF);
   endtask

   task automatic send_random_stream(input int count);
      int pick;
      int burst;
      int stop_at;
      stop_at = beats_sent + count;
      while (beats_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 78) begin
            send_record();
         end else if (pick < 88) begin
            burst = $urandom_range(1, 8);
            for (int i = 0; i < burst; i++) begin
               if ($urandom_range(0, 29) == 0) send_beat(FUNC_FLUSH, 8'($urandom_range(0, 255)));
               else send_beat(FUNC_DATA, noise_byte());
            end
         end else if (pick < 93) begin
            if ($urandom_range(0, 1) == 1) send_beat(FUNC_DATA, CH_CR);
            send_beat(FUNC_DATA, CH_LF);
         end else begin
            send_beat(FUNC_FLUSH, 8'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic test_field_extremes();
      send_beat(FUNC_DATA, 8'h00);
      send_beat(FUNC_DATA, 8'hFF);
      send_text(",\n");
   endtask

   task automatic test_quoting();
      // quoted field with a doubled quote, closing quote followed by a return
      send_text("\"a\"\"b\"");
      send_beat(FUNC_DATA, CH_CR);
      send_text("\n");
   endtask

   task automatic test_line_edges();
      send_text("\n");
      send_beat(FUNC_DATA, CH_CR);
      send_text("\n");
      // return in mid-line is kept as content
      send_text("x");
      send_beat(FUNC_DATA, CH_CR);
      send_text("y\n");
      // newline with quotes still open
      send_text("\"z\n");
      // end of data drops the held return but closes the record
      send_text("q");
      send_beat(FUNC_DATA, CH_CR);
      send_beat(FUNC_FLUSH, 8'hFF);
      send_beat(FUNC_FLUSH, 8'h00);
   endtask

   task automatic test_random_files();
      send_random_stream(RANDOM_BEATS);
   endtask

   task automatic test_back_to_back();
      back_to_back = 1'b1;
      send_random_stream(BURST_BEATS);
      back_to_back = 1'b0;
   endtask

   function automatic void report_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_ready_drv) begin
         if (expected_results.size() == 0) begin
            $display("%0t ns: unexpected response beat, expected none, actual kind %0d byte %0h",
                     $time, rsp_if.kind, rsp_if.out_byte);
            errors++;
         end else begin
            want = expected_results.pop_front();
            report_field("kind", 8'(want.kind), 8'(rsp_if.kind));
            report_field("out_byte", want.out_byte, rsp_if.out_byte);
            report_field("is_header", 8'(want.is_header), 8'(rsp_if.is_header));
            report_field("last_of_run", 8'(want.last_of_run), 8'(rsp_if.last_of_run));
            results_checked++;
            if (want.kind == KIND_RECORD_END) begin
               records_seen++;
               if (want.is_header) header_records++;
            end
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      @(negedge reset);
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
             (rsp_if.valid === 1'b1 && rsp_ready_drv)) quiet = 0;
         else quiet++;
      end
      $display("%0t ns: no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      req_if.valid     = 1'b0;
      req_if.func      = FUNC_DATA;
      req_if.data_byte = 8'h00;
      clear_line_state();
      header_due = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_field_extremes();
      test_quoting();
      test_line_edges();
      directed_beats = beats_sent;
      test_random_files();
      test_back_to_back();

      req_if.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d input beats (%0d directed), checked %0d response beats",
               beats_sent, directed_beats, results_checked);
      $display("records closed: %0d, of them header records: %0d, errors: %0d",
               records_seen, header_records, errors);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
